[rtl/md4_pkg.sv]
// Shared types, constants, tables and the control program of the MD4 digest block.
`timescale 1ns / 1ps
package md4_pkg;

    localparam int PC_W = 4;

    typedef logic [3:0][31:0] words4_t;

    localparam words4_t INIT_VECTOR = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};
    localparam logic [31:0] K_GROUP1 = 32'h5A827999;
    localparam logic [31:0] K_GROUP2 = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LAST_ROUND = 6'd47;
    localparam logic [5:0]  LAST_BYTE_POS = 6'd63;
    localparam logic [6:0]  LEN_POS = 7'd56;
    localparam logic [6:0]  BLOCK_BYTES = 7'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word_a;
        logic [31:0] digest_word_b;
        logic [31:0] digest_word_c;
        logic [31:0] digest_word_d;
    } out_word_t;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic       init;
        logic       step;
        logic [5:0] round_idx;
    } rnd_ctl_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MARK,
        OP_ZERO,
        OP_POS_CLR,
        OP_LEN,
        OP_EMIT,
        OP_INIT,
        OP_ROUND,
        OP_CHAIN
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_STAY,
        C_FULL,
        C_NOT_LAST,
        C_POS56,
        C_POS64,
        C_MORE_ROUNDS
    } cond_t;

    typedef enum logic [1:0] {
        L_JUMP,
        L_CALL,
        L_RET
    } link_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        link_t            link;
        logic [PC_W-1:0]  target;
    } uword_t;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_ACCEPT   = 4'd0;
    localparam logic [PC_W-1:0] PC_FULL     = 4'd1;
    localparam logic [PC_W-1:0] PC_LASTCHK  = 4'd2;
    localparam logic [PC_W-1:0] PC_MARK     = 4'd3;
    localparam logic [PC_W-1:0] PC_CHK56    = 4'd4;
    localparam logic [PC_W-1:0] PC_CHK64    = 4'd5;
    localparam logic [PC_W-1:0] PC_ZERO     = 4'd6;
    localparam logic [PC_W-1:0] PC_WRAP     = 4'd7;
    localparam logic [PC_W-1:0] PC_REFILL   = 4'd8;
    localparam logic [PC_W-1:0] PC_LEN      = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd10;
    localparam logic [PC_W-1:0] PC_CMP      = 4'd11;
    localparam logic [PC_W-1:0] PC_ROUND    = 4'd12;
    localparam logic [PC_W-1:0] PC_CHAIN    = 4'd13;

    // The control store. A true condition takes the link; otherwise the
    // program falls through to the next address.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{OP_NOP, C_NEVER, L_JUMP, PC_ACCEPT};
        case (pc)
            PC_ACCEPT:  w = '{OP_ACCEPT,  C_STAY,        L_JUMP, PC_ACCEPT};
            PC_FULL:    w = '{OP_NOP,     C_FULL,        L_CALL, PC_CMP};
            PC_LASTCHK: w = '{OP_NOP,     C_NOT_LAST,    L_JUMP, PC_ACCEPT};
            PC_MARK:    w = '{OP_MARK,    C_NEVER,       L_JUMP, PC_ACCEPT};
            PC_CHK56:   w = '{OP_NOP,     C_POS56,       L_JUMP, PC_LEN};
            PC_CHK64:   w = '{OP_NOP,     C_POS64,       L_JUMP, PC_WRAP};
            PC_ZERO:    w = '{OP_ZERO,    C_ALWAYS,      L_JUMP, PC_CHK56};
            PC_WRAP:    w = '{OP_POS_CLR, C_ALWAYS,      L_CALL, PC_CMP};
            PC_REFILL:  w = '{OP_NOP,     C_ALWAYS,      L_JUMP, PC_CHK56};
            PC_LEN:     w = '{OP_LEN,     C_ALWAYS,      L_CALL, PC_CMP};
            PC_EMIT:    w = '{OP_EMIT,    C_ALWAYS,      L_JUMP, PC_ACCEPT};
            PC_CMP:     w = '{OP_INIT,    C_NEVER,       L_JUMP, PC_ACCEPT};
            PC_ROUND:   w = '{OP_ROUND,   C_MORE_ROUNDS, L_JUMP, PC_ROUND};
            PC_CHAIN:   w = '{OP_CHAIN,   C_ALWAYS,      L_RET,  PC_ACCEPT};
            default:    w = '{OP_NOP,     C_ALWAYS,      L_JUMP, PC_ACCEPT};
        endcase
        return w;
    endfunction

    localparam logic [3:0] MSG_INDEX [48] = '{
        4'd0, 4'd1, 4'd2,  4'd3,  4'd4, 4'd5, 4'd6,  4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd8, 4'd4,  4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5,  4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };

    function automatic logic [3:0] msg_index(input logic [5:0] round_idx);
        logic [3:0] idx;
        idx = 4'd0;
        if (round_idx <= LAST_ROUND) begin
            idx = MSG_INDEX[round_idx];
        end
        return idx;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [5:0] round_idx);
        logic [4:0] s;
        unique case ({round_idx[5:4], round_idx[1:0]})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

endpackage

[rtl/md4_round_dp.sv]
// MD4 round datapath: four rotating working words and one round per step.
`timescale 1ns / 1ps
module md4_round_dp (
    input  logic                aclk,
    input  md4_pkg::rnd_ctl_t   ctl,
    input  md4_pkg::words4_t    chain_in,
    input  logic [31:0]         msg_word,
    output md4_pkg::words4_t    work_out
);

    md4_pkg::words4_t work_reg;
    md4_pkg::words4_t work_next;

    logic [31:0] fn;
    logic [31:0] k;
    logic [4:0]  s;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] new_word;

    // Word 0 is the one updated this round; the words rotate so that after
    // a multiple of four rounds they are back in chaining order.
    always_comb begin
        unique case (ctl.round_idx[5:4])
            2'd0: begin
                fn = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                k  = 32'h0;
            end
            2'd1: begin
                fn = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                   | (work_reg[2] & work_reg[3]);
                k  = md4_pkg::K_GROUP1;
            end
            default: begin
                fn = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k  = md4_pkg::K_GROUP2;
            end
        endcase
        s        = md4_pkg::shift_amt(ctl.round_idx);
        sum      = work_reg[0] + fn + msg_word + k;
        rot_wide = {sum, sum} << s;
        new_word = rot_wide[63:32];
    end

    always_comb begin
        work_next = work_reg;
        if (ctl.init) begin
            work_next = chain_in;
        end else if (ctl.step) begin
            work_next = {work_reg[2], work_reg[1], new_word, work_reg[3]};
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign work_out = work_reg;

endmodule

[rtl/md4_message_digest.sv]
// Top level of the MD4 message digest block: sequencer, block buffer and chaining words.
`timescale 1ns / 1ps
// The MD4 digest block takes a message one word at a time on the s_ channel,
// each word carrying one byte, a flag that says the byte is real and a flag
// that ends the message; an end flag with no byte present is allowed and
// gives the digest of whatever came before (the empty message if nothing
// did). Bytes are packed little-endian into a sixteen-word block buffer.
// When a block fills, it is compressed by 48 MD4 rounds into the four
// chaining words. At the end of a message the block is padded with 0x80,
// zeros and the 64-bit bit length, compressed, and the four chaining words
// leave on the m_ channel as one digest word; the block then restarts from
// the initial vector for the next message. Control is a fourteen-step
// program in a read-only control store: a program counter, one call level
// and a conditional jump on every step drive the byte buffer, the padding
// pointer and a shared round datapath that does one round per cycle.
// An ordinary byte is taken without leaving the accept step. A byte that
// fills a block calls the compression subroutine, which loads the working
// words, runs the 48 rounds and adds them into the chaining words. A word
// that ends a message writes the mark and then the zero padding bytes one
// at a time and compresses one block, or two where the mark lands in the
// last eight bytes of a block. The digest waits in an output register, so
// a new message can start while it is unread; the block only holds at the
// end of the next message if the previous digest has still not been taken.
module md4_message_digest (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  md4_pkg::in_word_t    s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output md4_pkg::out_word_t   m_word
);

    // Sequencer state.
    logic [md4_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [md4_pkg::PC_W-1:0] ret_reg, ret_next;
    md4_pkg::uword_t          uw;
    logic                     step_go;
    logic                     cond_true;

    // Message state.
    logic [60:0]              count_reg, count_next;
    logic [6:0]               pad_pos_reg, pad_pos_next;
    logic                     full_reg, full_next;
    logic                     last_reg, last_next;
    logic [5:0]               round_reg, round_next;
    md4_pkg::words4_t         chain_reg, chain_next;
    logic [15:0][31:0]        block_reg;

    // Byte and length writes into the block buffer.
    logic                     byte_we;
    logic [5:0]               byte_pos;
    logic [7:0]               byte_val;
    logic                     len_we;
    logic [63:0]              bit_len;

    // Output register.
    logic                     m_valid_reg, m_valid_next;
    md4_pkg::out_word_t       m_word_reg, m_word_next;
    logic                     out_free;

    md4_pkg::rnd_ctl_t        rnd_ctl;
    md4_pkg::words4_t         work;
    logic [31:0]              msg_word;
    logic                     in_full;

    assign uw       = md4_pkg::ucode(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (uw.op == md4_pkg::OP_ACCEPT);
    assign in_full  = s_word.byte_present && (count_reg[5:0] == md4_pkg::LAST_BYTE_POS);
    assign bit_len  = {count_reg, 3'b000};
    assign msg_word = block_reg[md4_pkg::msg_index(round_reg)];

    // A step that waits on a handshake holds the program counter and has
    // no effect until the handshake can complete.
    always_comb begin
        unique case (uw.op)
            md4_pkg::OP_ACCEPT: step_go = s_valid;
            md4_pkg::OP_EMIT:   step_go = out_free;
            default:            step_go = 1'b1;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            md4_pkg::C_NEVER:       cond_true = 1'b0;
            md4_pkg::C_ALWAYS:      cond_true = 1'b1;
            md4_pkg::C_STAY:        cond_true = !in_full && !s_word.message_end;
            md4_pkg::C_FULL:        cond_true = full_reg;
            md4_pkg::C_NOT_LAST:    cond_true = !last_reg;
            md4_pkg::C_POS56:       cond_true = (pad_pos_reg == md4_pkg::LEN_POS);
            md4_pkg::C_POS64:       cond_true = (pad_pos_reg == md4_pkg::BLOCK_BYTES);
            md4_pkg::C_MORE_ROUNDS: cond_true = (round_reg != md4_pkg::LAST_ROUND);
            default:                cond_true = 1'b0;
        endcase
    end

    // Next program address.
    always_comb begin
        pc_next  = pc_reg;
        ret_next = ret_reg;
        if (step_go) begin
            if (cond_true) begin
                unique case (uw.link)
                    md4_pkg::L_JUMP: pc_next = uw.target;
                    md4_pkg::L_CALL: begin
                        pc_next  = uw.target;
                        ret_next = pc_reg + 1'b1;
                    end
                    md4_pkg::L_RET:  pc_next = ret_reg;
                    default:         pc_next = uw.target;
                endcase
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    // Datapath effects of the current step.
    always_comb begin
        count_next   = count_reg;
        pad_pos_next = pad_pos_reg;
        full_next    = full_reg;
        last_next    = last_reg;
        round_next   = round_reg;
        chain_next   = chain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        byte_we      = 1'b0;
        byte_pos     = count_reg[5:0];
        byte_val     = s_word.data_byte;
        len_we       = 1'b0;
        rnd_ctl      = '{init: 1'b0, step: 1'b0, round_idx: round_reg};
        if (step_go) begin
            unique case (uw.op)
                md4_pkg::OP_ACCEPT: begin
                    byte_we   = s_word.byte_present;
                    full_next = in_full;
                    last_next = s_word.message_end;
                    if (s_word.byte_present) begin
                        count_next = count_reg + 61'd1;
                    end
                end
                md4_pkg::OP_MARK: begin
                    byte_we      = 1'b1;
                    byte_val     = md4_pkg::PAD_MARK;
                    pad_pos_next = {1'b0, count_reg[5:0]} + 7'd1;
                end
                md4_pkg::OP_ZERO: begin
                    byte_we      = 1'b1;
                    byte_pos     = pad_pos_reg[5:0];
                    byte_val     = 8'h00;
                    pad_pos_next = pad_pos_reg + 7'd1;
                end
                md4_pkg::OP_POS_CLR: pad_pos_next = 7'd0;
                md4_pkg::OP_LEN:     len_we = 1'b1;
                md4_pkg::OP_EMIT: begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{digest_word_a: chain_reg[0], digest_word_b: chain_reg[1],
                                     digest_word_c: chain_reg[2], digest_word_d: chain_reg[3]};
                    chain_next   = md4_pkg::INIT_VECTOR;
                    count_next   = 61'd0;
                end
                md4_pkg::OP_INIT: begin
                    rnd_ctl.init = 1'b1;
                    round_next   = 6'd0;
                end
                md4_pkg::OP_ROUND: begin
                    rnd_ctl.step = 1'b1;
                    round_next   = round_reg + 6'd1;
                end
                md4_pkg::OP_CHAIN: begin
                    for (int i = 0; i < 4; i++) begin
                        chain_next[i] = chain_reg[i] + work[i];
                    end
                    round_next = 6'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= md4_pkg::PC_ACCEPT;
            ret_reg     <= md4_pkg::PC_ACCEPT;
            count_reg   <= 61'd0;
            pad_pos_reg <= 7'd0;
            full_reg    <= 1'b0;
            last_reg    <= 1'b0;
            round_reg   <= 6'd0;
            chain_reg   <= md4_pkg::INIT_VECTOR;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            ret_reg     <= ret_next;
            count_reg   <= count_next;
            pad_pos_reg <= pad_pos_next;
            full_reg    <= full_next;
            last_reg    <= last_next;
            round_reg   <= round_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Block buffer and digest payload need no reset: every lane that is
    // compressed has been written first.
    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        if (byte_we) begin
            block_reg[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] <= byte_val;
        end
        if (len_we) begin
            block_reg[14] <= bit_len[31:0];
            block_reg[15] <= bit_len[63:32];
        end
    end

    md4_round_dp u_round (
        .aclk     (aclk),
        .ctl      (rnd_ctl),
        .chain_in (chain_reg),
        .msg_word (msg_word),
        .work_out (work)
    );

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // The round counter only moves inside the compression subroutine.
    a_round_local: assert property (@(posedge aclk) disable iff (!aresetn)
        (round_reg != 6'd0) |-> (pc_reg == md4_pkg::PC_ROUND || pc_reg == md4_pkg::PC_CHAIN))
        else $error("round counter nonzero outside the round loop");

    // Compression returns only to the step after one of its three call sites.
    a_ret_site: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == md4_pkg::PC_CHAIN) |-> (ret_reg == md4_pkg::PC_LASTCHK
            || ret_reg == md4_pkg::PC_REFILL || ret_reg == md4_pkg::PC_EMIT))
        else $error("compression return address is not a call site");

    // The padding pointer never runs past the end of a block.
    a_pad_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_pos_reg <= md4_pkg::BLOCK_BYTES)
        else $error("padding pointer beyond block end");

    // A digest leaves with the message state restarted behind it.
    a_emit_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == md4_pkg::OP_EMIT && out_free)
            |=> (m_valid_reg && count_reg == 61'd0 && chain_reg == md4_pkg::INIT_VECTOR))
        else $error("digest emitted without restarting the message state");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the byte-serial MD4 message digest block.
`timescale 1ns / 1ps
module testbench;

    // Run sizes and limits. A message end keeps the block busy through
    // padding and compression, and the long receiver stall below adds its own
    // stretch, so the watchdog allows several times the sum of the two.
    localparam int RANDOM_WORDS  = 1800;
    localparam int PRESSURE_HOLD = 600;
    localparam int DRAIN_CYCLES  = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int OWED_DEPTH    = 64;

    // Initial chaining words and round tables of MD4.
    localparam logic [31:0] CHAIN_IV [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };
    localparam logic [31:0] ROUND_ADD [3] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1};
    localparam int ROT_AMT [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};

    // Digests of "", "a" and "abc", each chaining word holding four digest
    // bytes in little-endian order.
    localparam md4_pkg::out_word_t DIGEST_EMPTY =
        '{32'he0cfd631, 32'h31e96ad1, 32'hd7593cb7, 32'hc089c0e0};
    localparam md4_pkg::out_word_t DIGEST_A     =
        '{32'hb32ce5bd, 32'h463ee31d, 32'hfb055e24, 32'h24fbd6db};
    localparam md4_pkg::out_word_t DIGEST_ABC   =
        '{32'h7a0148a4, 32'h52d821af, 32'he80ac15f, 32'h9d72a67a};

    typedef struct packed {
        md4_pkg::in_word_t  word;
        logic               typed;
        md4_pkg::out_word_t digest;
    } dir_row_t;

    // Directed words. A row with typed set carries the digest that its
    // message end must produce; the other rows are checked by the predictor.
    localparam int DIR_ROWS = 17;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},  // empty message
        '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},            // ignored word, no end
        '{'{8'h5A, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},  // end word, its byte ignored
        '{'{8'h61, 1'b1, 1'b1}, 1'b1, DIGEST_A},      // one byte that also ends
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1, DIGEST_ABC},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'hA5, 1'b0, 1'b0}, 1'b0, '0},            // ignored word inside a message
        '{'{8'hC3, 1'b0, 1'b1}, 1'b1, DIGEST_A},      // separate end word
        '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0, 1'b1}, 1'b0, '0},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'hFF, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h7F, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    md4_pkg::in_word_t  s_word  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    md4_pkg::out_word_t m_word;

    // Predictor state: chaining words, the bytes of the block being filled
    // and the message length in bytes.
    logic [31:0] chain_w [4];
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_bytes;

    // Digests still owed by the block, oldest first, in a ring with
    // free-running head and tail counts.
    md4_pkg::out_word_t owed_digests [OWED_DEPTH];
    int owed_head      = 0;
    int owed_tail      = 0;

    int mismatches     = 0;
    int words_taken    = 0;
    int bytes_taken    = 0;
    int ignored_taken  = 0;
    int ends_taken     = 0;
    int digests_seen   = 0;
    int idle_cycles    = 0;

    md4_message_digest dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One MD4 compression of the current block into the chaining words. The
    // word order of the second pass is a transpose of the 4x4 index grid and
    // that of the third pass is a 4-bit reversal of the round number.
    function automatic void compress_block();
        logic [31:0] v [4];
        logic [31:0] x, y, z, f, m;
        int grp, sub, dst, mi;
        for (int i = 0; i < 4; i++) begin
            v[i] = chain_w[i];
        end
        for (int r = 0; r < 48; r++) begin
            grp = r / 16;
            sub = r % 16;
            dst = (4 - (r % 4)) % 4;
            x = v[(dst + 1) % 4];
            y = v[(dst + 2) % 4];
            z = v[(dst + 3) % 4];
            case (grp)
                0: begin
                    f = (x & y) | (~x & z);
                    mi = sub;
                end
                1: begin
                    f = (x & y) | (x & z) | (y & z);
                    mi = (sub % 4) * 4 + sub / 4;
                end
                default: begin
                    f = x ^ y ^ z;
                    mi = ((sub & 1) << 3) | ((sub & 2) << 1) | ((sub & 4) >> 1) | ((sub & 8) >> 3);
                end
            endcase
            m = {block_bytes[4 * mi + 3], block_bytes[4 * mi + 2],
                 block_bytes[4 * mi + 1], block_bytes[4 * mi]};
            v[dst] = rotl(v[dst] + f + m + ROUND_ADD[grp], ROT_AMT[grp][r % 4]);
        end
        for (int i = 0; i < 4; i++) begin
            chain_w[i] = chain_w[i] + v[i];
        end
    endfunction

    // Takes one accepted word into the predictor. Returns 1 and the digest
    // when the word ends a message.
    function automatic bit absorb_word(input md4_pkg::in_word_t w,
                                       output md4_pkg::out_word_t digest);
        int pos;
        logic [63:0] bit_len;
        digest = '0;
        if (w.byte_present) begin
            block_bytes[msg_bytes[5:0]] = w.data_byte;
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0) begin
                compress_block();
            end
        end
        if (!w.message_end) begin
            return 1'b0;
        end
        // Padding: the marker byte, zeros, and the bit length in the last
        // eight bytes. A marker that lands past byte 55 needs an extra block.
        pos = int'(msg_bytes[5:0]);
        block_bytes[pos] = 8'h80;
        pos = pos + 1;
        if (pos > 56) begin
            while (pos < 64) begin
                block_bytes[pos] = 8'h00;
                pos = pos + 1;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos = pos + 1;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++) begin
            block_bytes[56 + i] = bit_len[8 * i +: 8];
        end
        compress_block();
        digest.digest_word_a = chain_w[0];
        digest.digest_word_b = chain_w[1];
        digest.digest_word_c = chain_w[2];
        digest.digest_word_d = chain_w[3];
        chain_w = CHAIN_IV;
        msg_bytes = '0;
        return 1'b1;
    endfunction

    // Offers one word, waits for the handshake, then updates the predictor.
    // A typed row replaces the predicted digest with the one it carries.
    // Ready is sampled at the falling edge, where it already holds the value
    // that the next rising edge sees.
    task automatic send_word(input md4_pkg::in_word_t w, input bit typed,
                             input md4_pkg::out_word_t known);
        int gap;
        bit took;
        md4_pkg::out_word_t predicted;
        gap = (((words_taken >> 6) % 4) == 3) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        words_taken++;
        if (w.byte_present) begin
            bytes_taken++;
        end else if (!w.message_end) begin
            ignored_taken++;
        end
        if (absorb_word(w, predicted)) begin
            ends_taken++;
            owed_digests[owed_tail % OWED_DEPTH] = typed ? known : predicted;
            owed_tail++;
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
        end
    endfunction

    // Result side. It idles a random number of cycles before each word,
    // with stretches of back-to-back reads. Twice it holds off for a long
    // stretch so that a digest waits in the output register and the next
    // message end stalls the input channel.
    initial begin : digest_sink
        int gap;
        bit took;
        md4_pkg::out_word_t got;
        md4_pkg::out_word_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (digests_seen == 1 || digests_seen == 24) begin
                m_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge aclk);
            end
            gap = (((digests_seen >> 3) % 4) == 2) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_valid;
                got  = m_word;
                @(posedge aclk);
            end while (!took);
            digests_seen++;
            if (owed_tail == owed_head) begin
                mismatches++;
                $display("%0t: digest with none expected, expected nothing, actual %032h",
                         $time, got);
            end else begin
                want = owed_digests[owed_head % OWED_DEPTH];
                owed_head++;
                compare_field("digest_word_a", want.digest_word_a, got.digest_word_a);
                compare_field("digest_word_b", want.digest_word_b, got.digest_word_b);
                compare_field("digest_word_c", want.digest_word_c, got.digest_word_c);
                compare_field("digest_word_d", want.digest_word_d, got.digest_word_d);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d digests still pending",
                     $time, IDLE_LIMIT, owed_tail - owed_head);
            $display("FAIL md4_message_digest");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int len;
        int msg_idx;
        int rand_start;
        bit end_on_byte;
        md4_pkg::in_word_t w;
        int boundary_lens [8];
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        chain_w = CHAIN_IV;
        msg_bytes = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(DIR_TABLE[r].word, DIR_TABLE[r].typed, DIR_TABLE[r].digest);
        end

        // Random messages. The first few sit on the padding boundaries: the
        // marker as the last byte before the length, the marker in the
        // length field (which needs a second block), and exact block fills.
        // After that, lengths lean toward short messages with a share near
        // the boundaries and a few long ones. About one word in ten inside a
        // message is an ignored word.
        rand_start = words_taken;
        msg_idx = 0;
        while ((words_taken - rand_start) < RANDOM_WORDS) begin
            if (msg_idx < 8) begin
                len = boundary_lens[msg_idx];
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: len = $urandom_range(0, 8);
                    3:       len = $urandom_range(52, 60);
                    4:       len = $urandom_range(61, 67);
                    5:       len = $urandom_range(116, 132);
                    6:       len = $urandom_range(0, 255);
                    default: len = $urandom_range(9, 51);
                endcase
            end
            end_on_byte = 1'($urandom_range(0, 1));
            for (int n = 0; n < len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w.data_byte    = 8'($urandom_range(0, 255));
                    w.byte_present = 1'b0;
                    w.message_end  = 1'b0;
                    send_word(w, 1'b0, '0);
                end
                w.data_byte    = 8'($urandom_range(0, 255));
                w.byte_present = 1'b1;
                w.message_end  = end_on_byte && (n == len - 1);
                send_word(w, 1'b0, '0);
            end
            if (len == 0 || !end_on_byte) begin
                w.data_byte    = 8'($urandom_range(0, 255));
                w.byte_present = 1'b0;
                w.message_end  = 1'b1;
                send_word(w, 1'b0, '0);
            end
            msg_idx++;
        end
        s_valid <= 1'b0;

        // Let every owed digest arrive, then give the block time to show a
        // stray one.
        while (owed_tail != owed_head) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d messages: %0d message bytes and %0d ignored words.",
                 ends_taken, bytes_taken, ignored_taken);
        $display("%0d digests compared, %0d field mismatches.", digests_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS md4_message_digest");
        end else begin
            $display("FAIL md4_message_digest");
        end
        $finish;
    end

endmodule

[md4_message_digest.f]
rtl/md4_pkg.sv
rtl/md4_round_dp.sv
rtl/md4_message_digest.sv
tb/sv/testbench.sv
